[sv/sbt_pkg.sv]
// Shared types, codes and constants for the software breakpoint table.
package sbt_pkg;

    localparam int NUM_SLOTS_DEF = 32;

    localparam logic [15:0] TRAP_RESET   = 16'h4e40;
    localparam logic [7:0]  MINLEN_RESET = 8'd2;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TRAP_OPCODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH  = 1'd1;

    localparam logic [1:0] REQ_INSERT     = 2'd0;
    localparam logic [1:0] REQ_DELETE     = 2'd1;
    localparam logic [1:0] REQ_REMOVE_ALL = 2'd2;

    localparam logic [1:0] ST_PATCHED   = 2'd0;
    localparam logic [1:0] ST_NO_CHANGE = 2'd1;
    localparam logic [1:0] ST_TOO_SHORT = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic latch;       // capture the input item
        logic scan_start;  // clear match flags, rewind slot counter
        logic scan_step;   // issue next lookup read, evaluate previous one
        logic ra_start;    // rewind slot counter for remove-all
        logic ra_skip;     // slot unused, advance
        logic ra_read;     // read the used slot's entry
        logic ra_load;     // emit restore patch and free the slot
        logic fin_load;    // emit the single result and commit the table update
    } sbt_cmd_t;

    typedef struct packed {
        logic [1:0] req;
        logic       empty;
        logic       scan_done;
        logic       out_free;
        logic       used_at_cnt;
        logic       ra_last;
    } sbt_stat_t;

endpackage

[sv/software_breakpoint_table_unit.sv]
// Insert and delete: decide, slot scan, then the final state, which waits for a free output.
// The lookup walks the slot memory one entry per cycle through its single read port.
// Remove-all skips unused slots and reads each used slot, emitting one result per used slot.
// Throughput: one item at a time; the next item is accepted once the last result is loaded.
// Reset (rst_n, async, active low) empties the table and loads the config reset values.
module software_breakpoint_table_unit #(
    parameter int NUM_SLOTS = sbt_pkg::NUM_SLOTS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [1:0]                       req_type,
    input  logic [31:0]                      bp_addr,
    input  logic [7:0]                       bp_length,
    input  logic [15:0]                      mem_word,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [1:0]                       status,
    output logic                             patch_valid,
    output logic [31:0]                      patch_addr,
    output logic [15:0]                      patch_value,
    output logic                             last,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sbt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sbt_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import sbt_pkg::*;

    sbt_cmd_t  cmd;
    sbt_stat_t stat;

    assign cfg_ready = 1'b1;

    sbt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sbt_datapath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .req_type    (req_type),
        .bp_addr     (bp_addr),
        .bp_length   (bp_length),
        .mem_word    (mem_word),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .patch_valid (patch_valid),
        .patch_addr  (patch_addr),
        .patch_value (patch_value),
        .last        (last)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item accepted while previous one in progress");

    a_patch_matches_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (patch_valid == (status == ST_PATCHED)))
        else $error("patch_valid disagrees with status");

    a_no_patch_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !patch_valid |-> (patch_addr == 32'd0) && (patch_value == 16'd0))
        else $error("nonzero patch fields without a patch");

    a_single_result_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_PATCHED |-> last)
        else $error("non-patch result not marked last");
`endif

endmodule

[sv/sbt_ctrl.sv]
// Request sequencer for the software breakpoint table.
module sbt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  sbt_pkg::sbt_stat_t stat,
    output sbt_pkg::sbt_cmd_t  cmd
);
    import sbt_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_DECIDE  = 3'd1;
    localparam logic [2:0] S_SCAN    = 3'd2;
    localparam logic [2:0] S_FIN     = 3'd3;
    localparam logic [2:0] S_RA_SCAN = 3'd4;
    localparam logic [2:0] S_RA_WAIT = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (stat.req == REQ_REMOVE_ALL)
                begin
                    if (stat.empty)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        cmd.ra_start = 1'b1;
                        state_next   = S_RA_SCAN;
                    end
                end
                else if (stat.req == REQ_INSERT || stat.req == REQ_DELETE)
                begin
                    // short lengths still scan; the result logic ranks them first
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.fin_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_RA_SCAN:
            begin
                if (stat.used_at_cnt)
                begin
                    cmd.ra_read = 1'b1;
                    state_next  = S_RA_WAIT;
                end
                else
                begin
                    cmd.ra_skip = 1'b1;
                end
            end
            S_RA_WAIT:
            begin
                if (stat.out_free)
                begin
                    cmd.ra_load = 1'b1;
                    state_next  = stat.ra_last ? S_IDLE : S_RA_SCAN;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[sv/sbt_datapath.sv]
// Slot table, lookup pipeline, configuration registers and result register.
module sbt_datapath #(
    parameter int NUM_SLOTS = sbt_pkg::NUM_SLOTS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  sbt_pkg::sbt_cmd_t                cmd,
    output sbt_pkg::sbt_stat_t               stat,
    input  logic [1:0]                       req_type,
    input  logic [31:0]                      bp_addr,
    input  logic [7:0]                       bp_length,
    input  logic [15:0]                      mem_word,
    input  logic                             cfg_valid,
    input  logic [sbt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sbt_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [1:0]                       status,
    output logic                             patch_valid,
    output logic [31:0]                      patch_addr,
    output logic [15:0]                      patch_value,
    output logic                             last
);
    import sbt_pkg::*;

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);

    // configuration
    logic [15:0] trap_opcode_reg;
    logic [7:0]  min_length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trap_opcode_reg <= TRAP_RESET;
            min_length_reg  <= MINLEN_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_TRAP_OPCODE: trap_opcode_reg <= cfg_data;
                CFG_MIN_LENGTH:  min_length_reg  <= cfg_data[7:0];
                default:         ;
            endcase
        end
    end

    // captured item
    logic [1:0]  req_reg;
    logic [31:0] addr_reg;
    logic [7:0]  len_reg;
    logic [15:0] word_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            req_reg  <= req_type;
            addr_reg <= bp_addr;
            len_reg  <= bp_length;
            word_reg <= mem_word;
        end
    end

    // slot table: used bits in flops, entries in memory
    logic [NUM_SLOTS-1:0] slot_used_reg;
    logic [NUM_SLOTS-1:0] slot_used_next;
    logic [31:0]          addr_mem [NUM_SLOTS];
    logic [15:0]          code_mem [NUM_SLOTS];
    logic [31:0]          rd_addr_reg;
    logic [15:0]          rd_code_reg;

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [IDX_W-1:0] cnt_idx;
    logic             cnt_end;
    logic             rd_en;

    assign cnt_idx = cnt_reg[IDX_W-1:0];
    assign cnt_end = (cnt_reg == CNT_W'(NUM_SLOTS));
    assign rd_en   = (cmd.scan_step && !cnt_end) || cmd.ra_read;

    // lookup pipeline stage and match flags
    logic             p1_vld_reg;
    logic [IDX_W-1:0] p1_idx_reg;
    logic             hit_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    logic [15:0]      hit_code_reg;
    logic             free_reg;
    logic [IDX_W-1:0] free_idx_reg;
    logic             p1_used;
    logic             p1_hit;
    logic             p1_free;

    assign p1_used = slot_used_reg[p1_idx_reg];
    assign p1_hit  = p1_vld_reg && p1_used && (rd_addr_reg == addr_reg);
    assign p1_free = p1_vld_reg && !p1_used && !free_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            p1_vld_reg <= 1'b0;
            hit_reg    <= 1'b0;
            free_reg   <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            p1_vld_reg <= cmd.scan_step && !cnt_end;
            if (cmd.scan_start)
            begin
                hit_reg  <= 1'b0;
                free_reg <= 1'b0;
            end
            else
            begin
                if (p1_hit)
                begin
                    hit_reg <= 1'b1;
                end
                if (p1_free)
                begin
                    free_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        p1_idx_reg <= cnt_idx;
        if (p1_hit)
        begin
            hit_idx_reg  <= p1_idx_reg;
            hit_code_reg <= rd_code_reg;
        end
        if (p1_free)
        begin
            free_idx_reg <= p1_idx_reg;
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.scan_start || cmd.ra_start)
        begin
            cnt_next = '0;
        end
        else if ((cmd.scan_step && !cnt_end) || cmd.ra_skip || cmd.ra_load)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    // final result of a single-result item
    logic        short_len;
    logic [1:0]  fin_status;
    logic        fin_patch;
    logic [15:0] fin_value;
    logic        do_insert;
    logic        do_delete;

    assign short_len = (len_reg < min_length_reg);

    always_comb
    begin
        fin_status = ST_NO_CHANGE;
        fin_patch  = 1'b0;
        fin_value  = '0;
        do_insert  = 1'b0;
        do_delete  = 1'b0;
        case (req_reg)
            REQ_INSERT:
            begin
                if (short_len)
                begin
                    fin_status = ST_TOO_SHORT;
                end
                else if (hit_reg)
                begin
                    fin_status = ST_NO_CHANGE;
                end
                else if (!free_reg)
                begin
                    fin_status = ST_FULL;
                end
                else
                begin
                    fin_status = ST_PATCHED;
                    fin_patch  = 1'b1;
                    fin_value  = trap_opcode_reg;
                    do_insert  = 1'b1;
                end
            end
            REQ_DELETE:
            begin
                if (short_len)
                begin
                    fin_status = ST_TOO_SHORT;
                end
                else if (hit_reg)
                begin
                    fin_status = ST_PATCHED;
                    fin_patch  = 1'b1;
                    fin_value  = hit_code_reg;
                    do_delete  = 1'b1;
                end
            end
            default:
            begin
                fin_status = ST_NO_CHANGE;
            end
        endcase
    end

    logic [NUM_SLOTS-1:0] cnt_mask;
    logic                 ra_last;

    assign cnt_mask = NUM_SLOTS'(1) << cnt_idx;
    // lower slots are already freed, so this is the highest used one
    assign ra_last  = ((slot_used_reg & ~cnt_mask) == '0);

    always_comb
    begin
        slot_used_next = slot_used_reg;
        if (cmd.fin_load && do_insert)
        begin
            slot_used_next[free_idx_reg] = 1'b1;
        end
        if (cmd.fin_load && do_delete)
        begin
            slot_used_next[hit_idx_reg] = 1'b0;
        end
        if (cmd.ra_load)
        begin
            slot_used_next[cnt_idx] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_used_reg <= '0;
        end
        else
        begin
            slot_used_reg <= slot_used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fin_load && do_insert)
        begin
            addr_mem[free_idx_reg] <= addr_reg;
            code_mem[free_idx_reg] <= word_reg;
        end
        if (rd_en)
        begin
            rd_addr_reg <= addr_mem[cnt_idx];
            rd_code_reg <= code_mem[cnt_idx];
        end
    end

    // result register
    logic        out_valid_reg;
    logic [1:0]  status_reg;
    logic        patch_valid_reg;
    logic [31:0] patch_addr_reg;
    logic [15:0] patch_value_reg;
    logic        last_reg;
    logic        out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.fin_load || cmd.ra_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fin_load)
        begin
            status_reg      <= fin_status;
            patch_valid_reg <= fin_patch;
            patch_addr_reg  <= fin_patch ? addr_reg : 32'd0;
            patch_value_reg <= fin_value;
            last_reg        <= 1'b1;
        end
        else if (cmd.ra_load)
        begin
            status_reg      <= ST_PATCHED;
            patch_valid_reg <= 1'b1;
            patch_addr_reg  <= rd_addr_reg;
            patch_value_reg <= rd_code_reg;
            last_reg        <= ra_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign patch_valid = patch_valid_reg;
    assign patch_addr  = patch_addr_reg;
    assign patch_value = patch_value_reg;
    assign last        = last_reg;

    assign stat.req         = req_reg;
    assign stat.empty       = (slot_used_reg == '0);
    assign stat.scan_done   = cnt_end && !p1_vld_reg;
    assign stat.out_free    = out_free;
    assign stat.used_at_cnt = slot_used_reg[cnt_idx];
    assign stat.ra_last     = ra_last;

endmodule
